@@ rtl/sfmr_pkg.sv @@
package sfmr_pkg;

  // Motor count and fixed-point formats.
  localparam int MOTOR_COUNT   = 4;
  localparam int IDX_W         = $clog2(MOTOR_COUNT);
  localparam int FRACTION_BITS = 16;
  localparam int TARGET_SHIFT  = FRACTION_BITS - 8;
  localparam int SPEED_W       = 24;
  localparam int MAG_W         = SPEED_W - 1;
  localparam int TARGET_W      = 16;
  localparam int STEP_W        = 24;
  localparam int ACCEL_W       = 16;
  localparam int RATE_W        = 15;
  localparam int PWM_W         = 16;
  localparam int DBAND_W       = 15;
  localparam int DIR_W         = 2;
  localparam int STATUS_W      = 2;

  // Target range check, in 1/256 percent.
  localparam logic signed [TARGET_W-1:0] TARGET_LIMIT = 16'sd25600;

  // 100 percent in the present speed format.
  localparam int FULL_SCALE_W = SPEED_W;
  localparam logic [FULL_SCALE_W-1:0] FULL_SCALE = FULL_SCALE_W'(100 << FRACTION_BITS);

  // Step saturation limit.
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  // Divider widths: numerator, divisor and quotient.
  localparam int DIV_N_W   = STEP_W + ACCEL_W + FRACTION_BITS;
  localparam int DIV_D_W   = STEP_W + RATE_W;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // Tick PWM arithmetic widths.
  localparam int PDIFF_W = PWM_W + 1;
  localparam int PROD_W  = MAG_W + 1 + PDIFF_W;
  localparam int NUMW_W  = PROD_W + 1;

  // PWM scaling: the numerator drops its fraction bits, then a reciprocal
  // multiply divides by 100 exactly over the whole numerator range.
  localparam int PWM_X_W     = NUMW_W - FRACTION_BITS;
  localparam int RECIP_SHIFT = PWM_X_W + 7;
  localparam int RECIP_W     = RECIP_SHIFT - 6;
  localparam logic [RECIP_W-1:0] PWM_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
  localparam int RPROD_W     = PWM_X_W + RECIP_W;

  // Request types.
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // APB address width: four word registers.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SET_OK     = 2'd0,
    STATUS_SET_REJECT = 2'd1,
    STATUS_TICK       = 2'd2
  } status_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_TICK_RATE = 2'd0,
    REG_PWM_FLOOR = 2'd1,
    REG_PWM_CEIL  = 2'd2,
    REG_DEAD_BAND = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]  tick_rate;
    logic [PWM_W-1:0]   pwm_floor;
    logic [PWM_W-1:0]   pwm_ceil;
    logic [DBAND_W-1:0] dead_band;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ST_DELTA,
    S_ST_MUL,
    S_ST_START,
    S_ST_DIV,
    S_TK_UPD,
    S_TK_MUL,
    S_TK_NUM,
    S_TK_RECIP,
    S_TK_PWM,
    S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DELTA,
    OP_SET_MUL,
    OP_DIV_START,
    OP_STEP_WR,
    OP_TICK_UPD,
    OP_TICK_MUL,
    OP_TICK_NUM,
    OP_TICK_RECIP,
    OP_PWM_WR,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic is_tick;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/sfmr_if.sv @@
// Input request channel.
interface sfmr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [sfmr_pkg::TARGET_W-1:0]  target_a;
  logic signed [sfmr_pkg::TARGET_W-1:0]  target_b;
  logic signed [sfmr_pkg::TARGET_W-1:0]  target_c;
  logic signed [sfmr_pkg::TARGET_W-1:0]  target_d;
  logic [sfmr_pkg::ACCEL_W-1:0]          accel;

  modport source (output valid, req_type, target_a, target_b, target_c, target_d, accel,
                  input ready);
  modport sink (input valid, req_type, target_a, target_b, target_c, target_d, accel,
                output ready);
endinterface

// Result channel.
interface sfmr_out_if;
  logic                            valid;
  logic                            ready;
  logic [sfmr_pkg::STATUS_W-1:0]   status;
  logic [sfmr_pkg::DIR_W-1:0]      dir_a;
  logic [sfmr_pkg::DIR_W-1:0]      dir_b;
  logic [sfmr_pkg::DIR_W-1:0]      dir_c;
  logic [sfmr_pkg::DIR_W-1:0]      dir_d;
  logic [sfmr_pkg::PWM_W-1:0]      pwm_a;
  logic [sfmr_pkg::PWM_W-1:0]      pwm_b;
  logic [sfmr_pkg::PWM_W-1:0]      pwm_c;
  logic [sfmr_pkg::PWM_W-1:0]      pwm_d;

  modport source (output valid, status, dir_a, dir_b, dir_c, dir_d,
                  pwm_a, pwm_b, pwm_c, pwm_d, input ready);
  modport sink (input valid, status, dir_a, dir_b, dir_c, dir_d,
                pwm_a, pwm_b, pwm_c, pwm_d, output ready);
endinterface

@@ rtl/sfmr_cfg.sv @@
module sfmr_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfmr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sfmr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sfmr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output sfmr_pkg::cfg_t                      cfg
);

  sfmr_pkg::cfg_t   cfg_r;
  sfmr_pkg::reg_idx_t sel;
  logic             wr_en;

  assign sel    = sfmr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_rate <= sfmr_pkg::RATE_W'(1000);
      cfg_r.pwm_floor <= '0;
      cfg_r.pwm_ceil  <= sfmr_pkg::PWM_W'(1000);
      cfg_r.dead_band <= sfmr_pkg::DBAND_W'(640);
    end else if (wr_en) begin
      case (sel)
        sfmr_pkg::REG_TICK_RATE: cfg_r.tick_rate <= pwdata[sfmr_pkg::RATE_W-1:0];
        sfmr_pkg::REG_PWM_FLOOR: cfg_r.pwm_floor <= pwdata[sfmr_pkg::PWM_W-1:0];
        sfmr_pkg::REG_PWM_CEIL:  cfg_r.pwm_ceil  <= pwdata[sfmr_pkg::PWM_W-1:0];
        sfmr_pkg::REG_DEAD_BAND: cfg_r.dead_band <= pwdata[sfmr_pkg::DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (sel)
      sfmr_pkg::REG_TICK_RATE: prdata = sfmr_pkg::CFG_DATA_W'(cfg_r.tick_rate);
      sfmr_pkg::REG_PWM_FLOOR: prdata = sfmr_pkg::CFG_DATA_W'(cfg_r.pwm_floor);
      sfmr_pkg::REG_PWM_CEIL:  prdata = sfmr_pkg::CFG_DATA_W'(cfg_r.pwm_ceil);
      sfmr_pkg::REG_DEAD_BAND: prdata = sfmr_pkg::CFG_DATA_W'(cfg_r.dead_band);
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ rtl/sfmr_div.sv @@
module sfmr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sfmr_pkg::DIV_N_W-1:0]      num,
  input  logic [sfmr_pkg::DIV_D_W-1:0]      den,
  output logic [sfmr_pkg::DIV_Q_W-1:0]      quot,
  output logic                              busy
);

  localparam int LOW_W = sfmr_pkg::DIV_Q_W;

  logic [sfmr_pkg::DIV_D_W-1:0]   rem_r;
  logic [LOW_W-1:0]               low_r;
  logic [sfmr_pkg::DIV_Q_W-1:0]   q_r;
  logic [sfmr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [sfmr_pkg::DIV_D_W:0]     shifted;
  logic [sfmr_pkg::DIV_D_W:0]     diff;
  logic                           ge;

  // One restoring step: shift in the next numerator bit and try the subtract.
  assign shifted = {rem_r, low_r[LOW_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};
  assign quot    = q_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= sfmr_pkg::DIV_CNT_W'(sfmr_pkg::DIV_Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == sfmr_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= sfmr_pkg::DIV_D_W'(num[sfmr_pkg::DIV_N_W-1:LOW_W]);
      low_r <= num[LOW_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[sfmr_pkg::DIV_D_W-1:0] : shifted[sfmr_pkg::DIV_D_W-1:0];
      low_r <= {low_r[LOW_W-2:0], 1'b0};
      q_r   <= {q_r[sfmr_pkg::DIV_Q_W-2:0], ge};
    end
  end

endmodule

@@ rtl/sfmr_dp.sv @@
module sfmr_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sfmr_pkg::cmd_t                         cmd,
  input  sfmr_pkg::cfg_t                         cfg,
  input  logic                                   in_req_type,
  input  logic signed [sfmr_pkg::TARGET_W-1:0]   in_tgt [sfmr_pkg::MOTOR_COUNT],
  input  logic [sfmr_pkg::ACCEL_W-1:0]           in_accel,
  input  logic                                   out_ready,
  output sfmr_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  output logic [sfmr_pkg::STATUS_W-1:0]          out_status,
  output logic [sfmr_pkg::DIR_W-1:0]             out_dir [sfmr_pkg::MOTOR_COUNT],
  output logic [sfmr_pkg::PWM_W-1:0]             out_pwm [sfmr_pkg::MOTOR_COUNT]
);

  localparam int MC = sfmr_pkg::MOTOR_COUNT;
  localparam int SW = sfmr_pkg::SPEED_W;

  // Captured request.
  logic                                 req_r;
  logic signed [sfmr_pkg::TARGET_W-1:0] tgt_r [MC];
  logic [sfmr_pkg::ACCEL_W-1:0]         accel_r;

  // Motor state.
  logic signed [SW-1:0]                 present_r [MC];
  logic signed [sfmr_pkg::TARGET_W-1:0] goal_r [MC];
  logic [sfmr_pkg::STEP_W-1:0]          step_r [MC];

  // Working registers.
  logic [SW-1:0]                        delta_r [MC];
  logic [SW-1:0]                        dmax_r;
  logic [sfmr_pkg::DIV_N_W-1:0]         num_r;
  logic [sfmr_pkg::DIV_D_W-1:0]         den_r;
  logic signed [sfmr_pkg::PROD_W-1:0]   prod_r;
  logic [sfmr_pkg::PWM_X_W-1:0]         pwm_x_r;
  logic [sfmr_pkg::RPROD_W-1:0]         rprod_r;
  logic [sfmr_pkg::DIR_W-1:0]           dir_w_r [MC];
  logic [sfmr_pkg::PWM_W-1:0]           pwm_w_r [MC];

  // Output register.
  logic                                 out_valid_r;
  logic [sfmr_pkg::STATUS_W-1:0]        out_status_r;
  logic [sfmr_pkg::DIR_W-1:0]           out_dir_r [MC];
  logic [sfmr_pkg::PWM_W-1:0]           out_pwm_r [MC];

  logic [sfmr_pkg::DIV_Q_W-1:0]         quot;
  logic                                 div_busy;
  logic                                 div_start;
  logic                                 bad;
  logic [sfmr_pkg::RATE_W-1:0]          rate_eff;

  // Per-cycle arithmetic on the selected motor.
  logic signed [SW-1:0]                 sel_present;
  logic signed [SW-1:0]                 tgt_ext;
  logic signed [SW-1:0]                 goal_ext;
  logic signed [SW:0]                   dsig;
  logic [SW-1:0]                        delta_abs;
  logic                                 goal_above;
  logic [SW:0]                          gap;
  logic [SW:0]                          move;
  logic signed [SW:0]                   s_new;
  logic [sfmr_pkg::MAG_W-1:0]           mag;
  logic [sfmr_pkg::MAG_W-1:0]           band;
  logic signed [sfmr_pkg::PDIFF_W-1:0]  pdiff;
  logic signed [sfmr_pkg::NUMW_W-1:0]   numw;
  logic [sfmr_pkg::STEP_W+sfmr_pkg::ACCEL_W-1:0] t_prod;
  logic [sfmr_pkg::DIV_D_W-1:0]         d_prod;
  logic [sfmr_pkg::STEP_W-1:0]          q_sat;

  // Validity of a set request.
  always_comb begin
    bad = (accel_r == '0);
    for (int i = 0; i < MC; i++) begin
      if (tgt_r[i] < -sfmr_pkg::TARGET_LIMIT || tgt_r[i] > sfmr_pkg::TARGET_LIMIT) begin
        bad = 1'b1;
      end
    end
  end

  assign rate_eff = (cfg.tick_rate == '0) ? sfmr_pkg::RATE_W'(1) : cfg.tick_rate;

  // Distance of the selected motor from its new target.
  assign sel_present = present_r[cmd.idx];
  assign tgt_ext     = SW'(tgt_r[cmd.idx]) <<< sfmr_pkg::TARGET_SHIFT;
  assign dsig        = (SW+1)'(sel_present) - (SW+1)'(tgt_ext);
  assign delta_abs   = dsig[SW] ? SW'(-dsig) : SW'(dsig);

  // Step products for the divider.
  assign t_prod = delta_r[cmd.idx] * accel_r;
  assign d_prod = dmax_r * rate_eff;

  // Ramp move toward the goal, limited by the step.
  assign goal_ext   = SW'(goal_r[cmd.idx]) <<< sfmr_pkg::TARGET_SHIFT;
  assign goal_above = goal_ext > sel_present;
  assign gap        = goal_above ? unsigned'((SW+1)'(goal_ext) - (SW+1)'(sel_present))
                                 : unsigned'((SW+1)'(sel_present) - (SW+1)'(goal_ext));
  assign move       = ((SW+1)'(step_r[cmd.idx]) < gap) ? (SW+1)'(step_r[cmd.idx]) : gap;
  assign s_new      = goal_above ? (SW+1)'(sel_present) + signed'(move)
                                 : (SW+1)'(sel_present) - signed'(move);

  // Magnitude, dead band and PWM numerator.
  assign mag   = sel_present[SW-1] ? sfmr_pkg::MAG_W'(-sel_present)
                                   : sfmr_pkg::MAG_W'(sel_present);
  assign band  = sfmr_pkg::MAG_W'(cfg.dead_band) << sfmr_pkg::TARGET_SHIFT;
  assign pdiff = signed'({1'b0, cfg.pwm_ceil}) - signed'({1'b0, cfg.pwm_floor});
  assign numw  = signed'(sfmr_pkg::NUMW_W'(cfg.pwm_floor * sfmr_pkg::FULL_SCALE))
                 + sfmr_pkg::NUMW_W'(prod_r);

  // Step saturation.
  assign q_sat = (quot > sfmr_pkg::DIV_Q_W'(sfmr_pkg::STEP_MAX)) ? sfmr_pkg::STEP_MAX
                                                                  : quot[sfmr_pkg::STEP_W-1:0];

  assign div_start = (cmd.op == sfmr_pkg::OP_DIV_START);

  sfmr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .quot  (quot),
    .busy  (div_busy)
  );

  // Motor state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MC; i++) begin
        present_r[i] <= '0;
        goal_r[i]    <= '0;
        step_r[i]    <= '0;
      end
    end else begin
      case (cmd.op)
        sfmr_pkg::OP_STEP_WR: begin
          step_r[cmd.idx] <= (dmax_r == '0) ? '0 : q_sat;
          goal_r[cmd.idx] <= tgt_r[cmd.idx];
        end
        sfmr_pkg::OP_TICK_UPD: present_r[cmd.idx] <= SW'(s_new);
        default: ;
      endcase
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      sfmr_pkg::OP_CAPTURE: begin
        req_r   <= in_req_type;
        accel_r <= in_accel;
        for (int i = 0; i < MC; i++) begin
          tgt_r[i] <= in_tgt[i];
        end
      end
      sfmr_pkg::OP_DELTA: begin
        delta_r[cmd.idx] <= delta_abs;
        if (cmd.idx == '0 || delta_abs > dmax_r) begin
          dmax_r <= delta_abs;
        end
      end
      sfmr_pkg::OP_SET_MUL: begin
        num_r <= sfmr_pkg::DIV_N_W'(t_prod) << sfmr_pkg::FRACTION_BITS;
        den_r <= d_prod;
      end
      sfmr_pkg::OP_TICK_MUL: begin
        prod_r <= signed'({1'b0, mag}) * pdiff;
        if (mag > band) begin
          dir_w_r[cmd.idx] <= sel_present[SW-1] ? sfmr_pkg::DIR_REV : sfmr_pkg::DIR_FWD;
        end else begin
          dir_w_r[cmd.idx] <= sfmr_pkg::DIR_STOP;
        end
      end
      // A negative numerator clamps to zero; the fraction bits are dropped here.
      sfmr_pkg::OP_TICK_NUM: begin
        pwm_x_r <= numw[sfmr_pkg::NUMW_W-1] ? '0
                   : numw[sfmr_pkg::NUMW_W-1:sfmr_pkg::FRACTION_BITS];
      end
      sfmr_pkg::OP_TICK_RECIP: rprod_r <= pwm_x_r * sfmr_pkg::PWM_RECIP;
      sfmr_pkg::OP_PWM_WR:
        pwm_w_r[cmd.idx] <= rprod_r[sfmr_pkg::RECIP_SHIFT +: sfmr_pkg::PWM_W];
      default: ;
    endcase
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == sfmr_pkg::OP_RESULT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.op == sfmr_pkg::OP_RESULT) begin
      if (req_r == sfmr_pkg::REQ_TICK) begin
        out_status_r <= sfmr_pkg::STATUS_TICK;
      end else if (bad) begin
        out_status_r <= sfmr_pkg::STATUS_SET_REJECT;
      end else begin
        out_status_r <= sfmr_pkg::STATUS_SET_OK;
      end
      for (int i = 0; i < MC; i++) begin
        out_dir_r[i] <= (req_r == sfmr_pkg::REQ_TICK) ? dir_w_r[i] : sfmr_pkg::DIR_STOP;
        out_pwm_r[i] <= (req_r == sfmr_pkg::REQ_TICK) ? pwm_w_r[i] : '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_dir    = out_dir_r;
  assign out_pwm    = out_pwm_r;

  assign stat.bad      = bad;
  assign stat.is_tick  = (req_r == sfmr_pkg::REQ_TICK);
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

@@ rtl/sfmr_ctrl.sv @@
module sfmr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfmr_pkg::dp_stat_t   stat,
  output sfmr_pkg::cmd_t       cmd
);

  sfmr_pkg::state_t              state_r, state_nxt;
  logic [sfmr_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                          last;

  assign last = (idx_r == sfmr_pkg::IDX_W'(sfmr_pkg::MOTOR_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfmr_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and motor index.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      sfmr_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfmr_pkg::S_CHECK;
      end
      sfmr_pkg::S_CHECK: begin
        idx_nxt = '0;
        if (stat.is_tick) begin
          state_nxt = sfmr_pkg::S_TK_UPD;
        end else if (stat.bad) begin
          state_nxt = sfmr_pkg::S_RESULT;
        end else begin
          state_nxt = sfmr_pkg::S_ST_DELTA;
        end
      end
      sfmr_pkg::S_ST_DELTA: begin
        if (last) begin
          idx_nxt   = '0;
          state_nxt = sfmr_pkg::S_ST_MUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      sfmr_pkg::S_ST_MUL:   state_nxt = sfmr_pkg::S_ST_START;
      sfmr_pkg::S_ST_START: state_nxt = sfmr_pkg::S_ST_DIV;
      sfmr_pkg::S_ST_DIV: begin
        if (!stat.div_busy) begin
          if (last) begin
            state_nxt = sfmr_pkg::S_RESULT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = sfmr_pkg::S_ST_MUL;
          end
        end
      end
      sfmr_pkg::S_TK_UPD:   state_nxt = sfmr_pkg::S_TK_MUL;
      sfmr_pkg::S_TK_MUL:   state_nxt = sfmr_pkg::S_TK_NUM;
      sfmr_pkg::S_TK_NUM:   state_nxt = sfmr_pkg::S_TK_RECIP;
      sfmr_pkg::S_TK_RECIP: state_nxt = sfmr_pkg::S_TK_PWM;
      sfmr_pkg::S_TK_PWM: begin
        if (last) begin
          state_nxt = sfmr_pkg::S_RESULT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = sfmr_pkg::S_TK_UPD;
        end
      end
      sfmr_pkg::S_RESULT: begin
        if (!stat.out_busy) state_nxt = sfmr_pkg::S_IDLE;
      end
      default: state_nxt = sfmr_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = sfmr_pkg::OP_NONE;
    cmd.idx  = idx_r;
    case (state_r)
      sfmr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = sfmr_pkg::OP_CAPTURE;
      end
      sfmr_pkg::S_ST_DELTA: cmd.op = sfmr_pkg::OP_DELTA;
      sfmr_pkg::S_ST_MUL:   cmd.op = sfmr_pkg::OP_SET_MUL;
      sfmr_pkg::S_ST_START: cmd.op = sfmr_pkg::OP_DIV_START;
      sfmr_pkg::S_ST_DIV: begin
        if (!stat.div_busy) cmd.op = sfmr_pkg::OP_STEP_WR;
      end
      sfmr_pkg::S_TK_UPD:   cmd.op = sfmr_pkg::OP_TICK_UPD;
      sfmr_pkg::S_TK_MUL:   cmd.op = sfmr_pkg::OP_TICK_MUL;
      sfmr_pkg::S_TK_NUM:   cmd.op = sfmr_pkg::OP_TICK_NUM;
      sfmr_pkg::S_TK_RECIP: cmd.op = sfmr_pkg::OP_TICK_RECIP;
      sfmr_pkg::S_TK_PWM:   cmd.op = sfmr_pkg::OP_PWM_WR;
      sfmr_pkg::S_RESULT: begin
        if (!stat.out_busy) cmd.op = sfmr_pkg::OP_RESULT;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/synced_four_motor_speed_ramp.sv @@
// Set request: four runs of the 32-step restoring divider, one per motor, give the
// step sizes; a rejected set goes straight to the result and skips the divider.
// Tick request: per motor, the update, multiply, numerator, reciprocal and PWM states.
// One transaction is in work at a time; the next is taken the cycle after the result
// is registered, and the block waits there while an earlier result is not taken.
// Synchronous active-low reset clears speeds, goals, steps and loads register defaults.
module synced_four_motor_speed_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  sfmr_in_if.sink                             in_ch,
  sfmr_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sfmr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [sfmr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [sfmr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  sfmr_pkg::cfg_t                       cfg;
  sfmr_pkg::cmd_t                       cmd;
  sfmr_pkg::dp_stat_t                   stat;
  logic signed [sfmr_pkg::TARGET_W-1:0] tgt [sfmr_pkg::MOTOR_COUNT];
  logic [sfmr_pkg::DIR_W-1:0]           dir [sfmr_pkg::MOTOR_COUNT];
  logic [sfmr_pkg::PWM_W-1:0]           pwm [sfmr_pkg::MOTOR_COUNT];

  assign tgt[0] = in_ch.target_a;
  assign tgt[1] = in_ch.target_b;
  assign tgt[2] = in_ch.target_c;
  assign tgt[3] = in_ch.target_d;

  sfmr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfmr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_req_type (in_ch.req_type),
    .in_tgt      (tgt),
    .in_accel    (in_ch.accel),
    .out_ready   (out_ch.ready),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_dir     (dir),
    .out_pwm     (pwm)
  );

  assign out_ch.dir_a = dir[0];
  assign out_ch.dir_b = dir[1];
  assign out_ch.dir_c = dir[2];
  assign out_ch.dir_d = dir[3];
  assign out_ch.pwm_a = pwm[0];
  assign out_ch.pwm_b = pwm[1];
  assign out_ch.pwm_c = pwm[2];
  assign out_ch.pwm_d = pwm[3];

endmodule
